### rtl/srec_record_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// srec_record_encoder_top_assert.svh
// assertion macros for the s-record encoder, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef SREC_RECORD_ENCODER_TOP_ASSERT_SVH
`define SREC_RECORD_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define SREC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srec encoder assertion failed");

// next-cycle implication
`define SREC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srec encoder assertion failed");

`endif

### rtl/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// shared constants, types and helpers of the s-record encoder
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int LEN_W        = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int DIDX_W       = (LEN_W > 3) ? LEN_W : 3;
  localparam int NAME_LEN     = 5;
  localparam int HDR_W        = 40;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 4;

  // register index, taken from paddr[3]
  localparam logic REG_HEADER_NAME = 1'b0;

  localparam logic [6:0] CHAR_S  = 7'd83;
  localparam logic [6:0] DIGIT_0 = 7'd48;
  localparam logic [6:0] DIGIT_1 = 7'd49;
  localparam logic [6:0] DIGIT_5 = 7'd53;
  localparam logic [6:0] DIGIT_9 = 7'd57;

  typedef enum logic [1:0] {REC_S0, REC_S1, REC_S5, REC_S9} rec_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TYPE, PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_DATA, PH_CSUM
  } phase_t;

  // one command per accepted word that produces output
  typedef struct packed {
    logic             hdr;
    logic             s1;
    logic             eof;
    logic [LEN_W-1:0] len;
    logic [15:0]      addr;
    logic             bank;
    logic [15:0]      s5_count;
  } cmd_t;

  typedef struct packed {
    logic           en;
    logic [IDX_W:0] addr;
    logic [7:0]     data;
  } buf_wr_t;

  typedef struct packed {
    logic done;
    logic bank;
  } buf_rel_t;

  function automatic logic [6:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (7'd48 + {3'b000, v}) : (7'd55 + {3'b000, v});
  endfunction

endpackage

### rtl/srec_cmd_queue.sv
// ----------------------------------------------------------------------------
// srec_cmd_queue
// two-entry command queue between the front and back sequencer
// ----------------------------------------------------------------------------
module srec_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srec_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output srec_pkg::cmd_t   head,
  output logic             empty,
  output logic             full
);

  srec_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/srec_front.sv
// ----------------------------------------------------------------------------
// srec_front
// accepts input words, fills the byte banks and issues record commands
// ----------------------------------------------------------------------------
module srec_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                has_data,
  input  logic                end_of_file,
  input  logic                q_full,
  output logic                q_push,
  output srec_pkg::cmd_t      q_cmd,
  output srec_pkg::buf_wr_t   buf_wr,
  input  srec_pkg::buf_rel_t  buf_rel
);

  logic [srec_pkg::LEN_W-1:0] fill_count;
  logic [15:0]                record_counter;
  logic                       header_sent;
  logic                       wbank;
  logic [1:0]                 busy;

  logic                       accept;
  logic                       do_write;
  logic [srec_pkg::LEN_W-1:0] fill_after;
  logic                       full_flush;
  logic                       s1;
  logic [15:0]                rc_after;

  assign full   = q_full || busy[wbank];
  assign accept = push && !full;

  always_comb begin
    do_write   = has_data && (fill_count < srec_pkg::LEN_W'(srec_pkg::RECORD_BYTES));
    fill_after = do_write ? fill_count + srec_pkg::LEN_W'(1) : fill_count;
    full_flush = has_data && (fill_after >= srec_pkg::LEN_W'(srec_pkg::RECORD_BYTES));
    s1         = full_flush || (end_of_file && (fill_after != '0));
    rc_after   = s1 ? record_counter + 16'd1 : record_counter;

    q_cmd.hdr      = !header_sent;
    q_cmd.s1       = s1;
    q_cmd.eof      = end_of_file;
    q_cmd.len      = fill_after;
    q_cmd.addr     = 16'(32'(record_counter) * srec_pkg::RECORD_BYTES);
    q_cmd.bank     = wbank;
    q_cmd.s5_count = rc_after;
    q_push         = accept && (!header_sent || s1 || end_of_file);

    buf_wr.en   = accept && do_write;
    buf_wr.addr = {wbank, fill_count[srec_pkg::IDX_W-1:0]};
    buf_wr.data = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      record_counter <= 16'd0;
      header_sent    <= 1'b0;
      wbank          <= 1'b0;
      busy           <= 2'b00;
    end else begin
      if (buf_rel.done) begin
        busy[buf_rel.bank] <= 1'b0;
      end
      if (accept) begin
        if (s1) begin
          busy[wbank] <= 1'b1;
          wbank       <= ~wbank;
        end
        if (end_of_file) begin
          fill_count     <= '0;
          record_counter <= 16'd0;
          header_sent    <= 1'b0;
        end else begin
          fill_count     <= s1 ? '0 : fill_after;
          record_counter <= rc_after;
          header_sent    <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/srec_back.sv
// ----------------------------------------------------------------------------
// srec_back
// record sequencer: turns commands into character pairs; while pop keeps the output free, one pair a cycle
// ----------------------------------------------------------------------------
module srec_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [srec_pkg::HDR_W-1:0]        header_name,
  input  srec_pkg::cmd_t                    q_head,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  srec_pkg::buf_wr_t                 buf_wr,
  output srec_pkg::buf_rel_t                buf_rel,
  output logic                              out_valid,
  input  logic                              pop,
  output logic [6:0]                        char_high,
  output logic [6:0]                        char_low,
  output logic                              end_of_line,
  output logic                              last_of_run
);

  logic [7:0] mem [2**(srec_pkg::IDX_W+1)];
  logic [7:0] rd_data;

  srec_pkg::phase_t            phase, phase_next;
  srec_pkg::rec_t              rec, rec_next;
  srec_pkg::cmd_t              cmd, cmd_next;
  logic [7:0]                  csum, csum_next;
  logic [srec_pkg::DIDX_W-1:0] idx, idx_next;
  logic                        bank, bank_next;

  logic                        free;
  logic                        load_out;
  logic [6:0]                  pair_hi;
  logic [6:0]                  pair_lo;
  logic                        pair_eol;
  logic                        pair_lor;
  logic [srec_pkg::DIDX_W-1:0] len_cur;
  logic [15:0]                 addr_cur;
  logic [6:0]                  type_digit;
  logic [7:0]                  hdr_byte;
  logic [7:0]                  cur_byte;
  logic                        more;
  srec_pkg::rec_t              rec_after;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
    // prefetch: the word for the coming data index is ready when it is needed
    rd_data <= mem[{bank_next, idx_next[srec_pkg::IDX_W-1:0]}];
  end

  always_comb begin
    case (idx)
      srec_pkg::DIDX_W'(0): hdr_byte = header_name[39:32];
      srec_pkg::DIDX_W'(1): hdr_byte = header_name[31:24];
      srec_pkg::DIDX_W'(2): hdr_byte = header_name[23:16];
      srec_pkg::DIDX_W'(3): hdr_byte = header_name[15:8];
      srec_pkg::DIDX_W'(4): hdr_byte = header_name[7:0];
      default:              hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    unique case (rec)
      srec_pkg::REC_S0: begin
        len_cur    = srec_pkg::DIDX_W'(srec_pkg::NAME_LEN);
        addr_cur   = 16'd0;
        type_digit = srec_pkg::DIGIT_0;
      end
      srec_pkg::REC_S1: begin
        len_cur    = srec_pkg::DIDX_W'(cmd.len);
        addr_cur   = cmd.addr;
        type_digit = srec_pkg::DIGIT_1;
      end
      srec_pkg::REC_S5: begin
        len_cur    = '0;
        addr_cur   = cmd.s5_count;
        type_digit = srec_pkg::DIGIT_5;
      end
      default: begin
        len_cur    = '0;
        addr_cur   = 16'd0;
        type_digit = srec_pkg::DIGIT_9;
      end
    endcase

    // record that follows the current one inside this command
    unique case (rec)
      srec_pkg::REC_S0: begin
        more      = cmd.s1 || cmd.eof;
        rec_after = cmd.s1 ? srec_pkg::REC_S1 : srec_pkg::REC_S5;
      end
      srec_pkg::REC_S1: begin
        more      = cmd.eof;
        rec_after = srec_pkg::REC_S5;
      end
      srec_pkg::REC_S5: begin
        more      = 1'b1;
        rec_after = srec_pkg::REC_S9;
      end
      default: begin
        more      = 1'b0;
        rec_after = srec_pkg::REC_S9;
      end
    endcase

    case (phase)
      srec_pkg::PH_COUNT:   cur_byte = 8'(len_cur) + 8'd3;
      srec_pkg::PH_ADDR_HI: cur_byte = addr_cur[15:8];
      srec_pkg::PH_ADDR_LO: cur_byte = addr_cur[7:0];
      srec_pkg::PH_DATA:    cur_byte = (rec == srec_pkg::REC_S0) ? hdr_byte : rd_data;
      default:              cur_byte = ~csum;
    endcase
  end

  always_comb begin
    phase_next = phase;
    rec_next   = rec;
    cmd_next   = cmd;
    csum_next  = csum;
    idx_next   = idx;
    bank_next  = bank;
    q_pop      = 1'b0;
    buf_rel    = '0;
    load_out   = 1'b0;
    pair_hi    = srec_pkg::hex_char(cur_byte[7:4]);
    pair_lo    = srec_pkg::hex_char(cur_byte[3:0]);
    pair_eol   = 1'b0;
    pair_lor   = 1'b0;
    free       = !out_valid || pop;

    unique case (phase)
      srec_pkg::PH_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cmd_next   = q_head;
          bank_next  = q_head.bank;
          phase_next = srec_pkg::PH_TYPE;
          rec_next   = q_head.hdr ? srec_pkg::REC_S0 :
                       (q_head.s1 ? srec_pkg::REC_S1 : srec_pkg::REC_S5);
        end
      end
      srec_pkg::PH_TYPE: begin
        pair_hi = srec_pkg::CHAR_S;
        pair_lo = type_digit;
        if (free) begin
          load_out   = 1'b1;
          csum_next  = 8'h00;
          phase_next = srec_pkg::PH_COUNT;
        end
      end
      srec_pkg::PH_COUNT: begin
        if (free) begin
          load_out   = 1'b1;
          csum_next  = csum + cur_byte;
          phase_next = srec_pkg::PH_ADDR_HI;
        end
      end
      srec_pkg::PH_ADDR_HI: begin
        if (free) begin
          load_out   = 1'b1;
          csum_next  = csum + cur_byte;
          phase_next = srec_pkg::PH_ADDR_LO;
        end
      end
      srec_pkg::PH_ADDR_LO: begin
        if (free) begin
          load_out   = 1'b1;
          csum_next  = csum + cur_byte;
          idx_next   = '0;
          phase_next = (len_cur != '0) ? srec_pkg::PH_DATA : srec_pkg::PH_CSUM;
        end
      end
      srec_pkg::PH_DATA: begin
        if (free) begin
          load_out  = 1'b1;
          csum_next = csum + cur_byte;
          if (idx == len_cur - srec_pkg::DIDX_W'(1)) begin
            phase_next = srec_pkg::PH_CSUM;
          end else begin
            idx_next = idx + srec_pkg::DIDX_W'(1);
          end
        end
      end
      srec_pkg::PH_CSUM: begin
        pair_eol = 1'b1;
        pair_lor = !more;
        if (free) begin
          load_out     = 1'b1;
          buf_rel.done = (rec == srec_pkg::REC_S1);
          buf_rel.bank = bank;
          if (more) begin
            rec_next   = rec_after;
            phase_next = srec_pkg::PH_TYPE;
          end else begin
            phase_next = srec_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = srec_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= srec_pkg::PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec  <= rec_next;
    cmd  <= cmd_next;
    csum <= csum_next;
    idx  <= idx_next;
    bank <= bank_next;
    if (load_out) begin
      char_high   <= pair_hi;
      char_low    <= pair_lo;
      end_of_line <= pair_eol;
      last_of_run <= pair_lor;
    end
  end

endmodule

### rtl/srec_record_encoder_top.sv
// ----------------------------------------------------------------------------
// srec_record_encoder_top
// motorola s-record (s19) text encoder with an apb register port
// ----------------------------------------------------------------------------
// usage
//   input queue: push a word (data_byte, has_data, end_of_file) while full
//   is low. output queue: while empty is low the oldest character pair is on
//   char_high/char_low with end_of_line and last_of_run; pop takes it.
//   the first word of an image brings an s0 header with header_name (apb
//   address 0, 64-bit data, low 40 bits used). every RECORD_BYTES data bytes
//   make an s1 record; end_of_file flushes a partial s1, then s5 and s9.
// flow
//   the front takes one word a cycle into a pair of byte banks; it stalls
//   only when the command queue is full or the bank to fill is still being
//   sent. the back sequencer sends one pair per cycle while pop keeps the
//   output free, and loads each command in its idle state, sending no pair.
//   the first pair of a word is registered in the command queue, taken by
//   the back from its idle state, then loaded into the output register.
// reset and stalls
//   rst clears the image state, the queue and header_name. when pop stays
//   low the current pair holds, the back stops, and the front fills up and
//   raises full.
// ----------------------------------------------------------------------------
`include "srec_record_encoder_top_assert.svh"

module srec_record_encoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srec_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [srec_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [srec_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        data_byte,
  input  logic                              has_data,
  input  logic                              end_of_file,
  output logic                              empty,
  input  logic                              pop,
  output logic [6:0]                        char_high,
  output logic [6:0]                        char_low,
  output logic                              end_of_line,
  output logic                              last_of_run
);

  logic [srec_pkg::HDR_W-1:0] header_name;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  srec_pkg::cmd_t             q_cmd;
  srec_pkg::cmd_t             q_head;
  srec_pkg::buf_wr_t          buf_wr;
  srec_pkg::buf_rel_t         buf_rel;
  logic                       out_valid;
  logic                       type_char_ok;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == srec_pkg::REG_HEADER_NAME) ?
                  srec_pkg::CFG_DATA_W'(header_name) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_name <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[3] == srec_pkg::REG_HEADER_NAME)) begin
      header_name <= pwdata[srec_pkg::HDR_W-1:0];
    end
  end

  srec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .has_data    (has_data),
    .end_of_file (end_of_file),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .buf_wr      (buf_wr),
    .buf_rel     (buf_rel)
  );

  srec_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  srec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .header_name (header_name),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .buf_wr      (buf_wr),
    .buf_rel     (buf_rel),
    .out_valid   (out_valid),
    .pop         (pop),
    .char_high   (char_high),
    .char_low    (char_low),
    .end_of_line (end_of_line),
    .last_of_run (last_of_run)
  );

  assign empty = !out_valid;

  assign type_char_ok = (char_low == srec_pkg::DIGIT_0) || (char_low == srec_pkg::DIGIT_1) ||
                        (char_low == srec_pkg::DIGIT_5) || (char_low == srec_pkg::DIGIT_9);

  `SREC_ASSERT_IMPL(a_type_digit, !empty && (char_high == srec_pkg::CHAR_S), type_char_ok)
  `SREC_ASSERT_IMPL(a_run_ends_line, !empty && last_of_run, end_of_line)
  `SREC_ASSERT_IMPL(a_reset_empty, $past(rst), empty)
  `SREC_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable({char_high, char_low}))

endmodule

### tb/tb_srec_record_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_srec_record_encoder_top
// self-checking bench for the s-record encoder
// ----------------------------------------------------------------------------
// a short table of directed words comes first. Rows whose text is obvious
// carry the expected s-record text. All other rows, and the random images
// that follow, are checked against a behavioral encoder kept in this bench.
// header_name is rewritten between phases, only while the block is drained.
// Both queue sides idle at random. Once, the reader holds off long enough
// for the block to fill up and raise full.
// ----------------------------------------------------------------------------
module tb_srec_record_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_AT       = 125;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_WORDS   = 36;
  localparam int NUM_PHASES    = 4;
  localparam int NUM_ROWS      = 23;
  localparam int MAX_REPORTS   = 10;
  localparam byte NEWLINE      = 8'h0A;
  localparam logic [srec_pkg::CFG_ADDR_W-1:0] HDR_NAME_ADDR =
    srec_pkg::CFG_ADDR_W'({srec_pkg::REG_HEADER_NAME, 3'b000});

  // one character pair as it leaves the block
  typedef struct {
    logic [6:0] hi;
    logic [6:0] lo;
    logic       eol;
    logic       lor;
  } pair_t;

  // directed word; text, when given, is the exact s-record output it causes
  typedef struct {
    logic [7:0] d;
    logic       hd;
    logic       eof;
    string      text;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [srec_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [srec_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [srec_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            push = 1'b0;
  logic                            full;
  logic [7:0]                      data_byte = '0;
  logic                            has_data = 1'b0;
  logic                            end_of_file = 1'b0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic [6:0]                      char_high;
  logic [6:0]                      char_low;
  logic                            end_of_line;
  logic                            last_of_run;

  srec_record_encoder_top u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // encoder image state
  logic [7:0]  img_buf [srec_pkg::RECORD_BYTES];
  int          img_fill = 0;
  logic [15:0] img_records = '0;
  bit          img_header_sent = 1'b0;
  logic [39:0] name_cfg = '0;

  pair_t word_pairs[$];
  pair_t pending_pairs[$];

  int  errors = 0;
  int  pops = 0;
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  bit  took;
  bit  sender_calm = 1'b0;
  int  quiet = 0;

  dir_row_t dir_rows [NUM_ROWS] = '{
    // empty image
    '{8'h00, 1'b0, 1'b1, "S00800000000000000F7\nS5030000FC\nS9030000FC\n"},
    // bare first word still brings the header
    '{8'h00, 1'b0, 1'b0, "S00800000000000000F7\n"},
    // bare idle word, data ignored
    '{8'hFF, 1'b0, 1'b0, ""},
    '{8'hFF, 1'b1, 1'b0, ""}, '{8'h00, 1'b1, 1'b0, ""}, '{8'h80, 1'b1, 1'b0, ""},
    '{8'h7F, 1'b1, 1'b0, ""}, '{8'h01, 1'b1, 1'b0, ""}, '{8'hFE, 1'b1, 1'b0, ""},
    '{8'h55, 1'b1, 1'b0, ""}, '{8'hAA, 1'b1, 1'b0, ""}, '{8'h0F, 1'b1, 1'b0, ""},
    '{8'hF0, 1'b1, 1'b0, ""}, '{8'h12, 1'b1, 1'b0, ""}, '{8'h34, 1'b1, 1'b0, ""},
    '{8'h9A, 1'b1, 1'b0, ""}, '{8'hBC, 1'b1, 1'b0, ""}, '{8'hDE, 1'b1, 1'b0, ""},
    // sixteenth byte closes a full s1
    '{8'hFF, 1'b1, 1'b0, ""},
    // partial s1 flushed at end of file
    '{8'hC3, 1'b1, 1'b1, ""},
    // one-byte image in a single word
    '{8'h00, 1'b1, 1'b1, "S00800000000000000F7\nS104000000FB\nS5030001FB\nS9030000FC\n"},
    '{8'h99, 1'b1, 1'b0, ""},
    // bare end marker after data
    '{8'h00, 1'b0, 1'b1, ""}
  };

  function automatic logic [6:0] hex_ascii(input logic [3:0] v);
    return (v < 4'd10) ? 7'(8'h30 + v) : 7'(8'h37 + v);
  endfunction

  task automatic add_pair(input logic [6:0] hi, input logic [6:0] lo, input logic eol);
    pair_t p;
    p.hi  = hi;
    p.lo  = lo;
    p.eol = eol;
    p.lor = 1'b0;
    word_pairs.push_back(p);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eol);
    add_pair(hex_ascii(b[7:4]), hex_ascii(b[3:0]), eol);
  endtask

  task automatic add_record(input logic [6:0] type_digit, input logic [15:0] addr,
                            input logic [7:0] payload[$]);
    logic [7:0] count;
    logic [7:0] csum;
    count = 8'(payload.size() + 3);
    csum  = count + addr[15:8] + addr[7:0];
    foreach (payload[i]) csum += payload[i];
    add_pair(srec_pkg::CHAR_S, type_digit, 1'b0);
    add_byte(count, 1'b0);
    add_byte(addr[15:8], 1'b0);
    add_byte(addr[7:0], 1'b0);
    foreach (payload[i]) add_byte(payload[i], 1'b0);
    add_byte(~csum, 1'b1);
  endtask

  task automatic flush_data_record();
    logic [7:0] payload[$];
    for (int i = 0; i < img_fill; i++) payload.push_back(img_buf[i]);
    add_record(srec_pkg::DIGIT_1, 16'(img_records * srec_pkg::RECORD_BYTES), payload);
    img_records = img_records + 16'd1;
    img_fill    = 0;
  endtask

  // s-record text caused by one accepted word, left in word_pairs
  task automatic encode_word(input logic [7:0] d, input logic hd, input logic eof);
    logic [7:0] payload[$];
    word_pairs.delete();
    if (!img_header_sent) begin
      for (int i = srec_pkg::NAME_LEN - 1; i >= 0; i--) payload.push_back(name_cfg[8*i +: 8]);
      add_record(srec_pkg::DIGIT_0, 16'h0000, payload);
      img_header_sent = 1'b1;
    end
    if (hd) begin
      if (img_fill < srec_pkg::RECORD_BYTES) begin
        img_buf[img_fill] = d;
        img_fill++;
      end
      if (img_fill >= srec_pkg::RECORD_BYTES) flush_data_record();
    end
    if (eof) begin
      payload.delete();
      if (img_fill > 0) flush_data_record();
      add_record(srec_pkg::DIGIT_5, img_records, payload);
      add_record(srec_pkg::DIGIT_9, 16'h0000, payload);
      img_fill        = 0;
      img_records     = '0;
      img_header_sent = 1'b0;
    end
    if (word_pairs.size() > 0) word_pairs[word_pairs.size()-1].lor = 1'b1;
  endtask

  task automatic load_text(input string txt);
    int i;
    i = 0;
    word_pairs.delete();
    while (i < txt.len()) begin
      if (txt[i] == NEWLINE) begin
        word_pairs[word_pairs.size()-1].eol = 1'b1;
        i++;
      end else begin
        add_pair(7'(txt[i]), 7'(txt[i+1]), 1'b0);
        i += 2;
      end
    end
    if (word_pairs.size() > 0) word_pairs[word_pairs.size()-1].lor = 1'b1;
  endtask

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [7:0] d, input logic hd, input logic eof,
                           input string txt);
    data_byte   <= d;
    has_data    <= hd;
    end_of_file <= eof;
    push        <= 1'b1;
    do @(posedge clk); while (full);
    encode_word(d, hd, eof);
    if (txt.len() > 0) load_text(txt);
    foreach (word_pairs[i]) pending_pairs.push_back(word_pairs[i]);
  endtask

  task automatic sender_gap();
    int g;
    g = sender_calm ? 0 : next_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_header_name(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HDR_NAME_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    name_cfg = value[srec_pkg::HDR_W-1:0];
  endtask

  // mostly well-formed images of random length, some idle words mixed in
  task automatic random_images(input int quota);
    int done_words;
    int len;
    bit eof_on_last;
    done_words = 0;
    while (done_words < quota) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 20);
      eof_on_last = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom), 1'b0, 1'b0, "");
        sender_gap();
        done_words++;
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(8'($urandom), 1'b0, 1'b0, "");
          sender_gap();
        end
        send_word(8'($urandom), 1'b1, eof_on_last && (i == len - 1), "");
        sender_gap();
        done_words++;
      end
      if (len == 0 || !eof_on_last) begin
        send_word(8'($urandom), 1'b0, 1'b1, "");
        sender_gap();
        done_words++;
      end
    end
  endtask

  task automatic check_pair();
    pair_t want;
    if (pending_pairs.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected word: hi=%0h lo=%0h eol=%0b last=%0b",
                 char_high, char_low, end_of_line, last_of_run);
    end else begin
      want = pending_pairs.pop_front();
      if (char_high !== want.hi || char_low !== want.lo ||
          end_of_line !== want.eol || last_of_run !== want.lor) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: exp hi=%0h lo=%0h eol=%0b last=%0b, got hi=%0h lo=%0h eol=%0b last=%0b",
                   want.hi, want.lo, want.eol, want.lor,
                   char_high, char_low, end_of_line, last_of_run);
      end
    end
  endtask

  // reader side: random gaps, calm stretches, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      took = pop && !empty;
      if (took) begin
        check_pair();
        pops++;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (pops >= HOLD_AT && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (took && ((pops / 96) % 3 != 1)) begin
        stall_left = next_gap();
      end
      pop <= (stall_left == 0);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [63:0] name_val;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].d, dir_rows[i].hd, dir_rows[i].eof, dir_rows[i].text);
      sender_gap();
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: name_val = {24'($urandom), 40'hFF_FFFF_FFFF};
        NUM_PHASES - 1: name_val = {24'($urandom), 40'h0};
        default: name_val = {32'($urandom), 32'($urandom)};
      endcase
      write_header_name(name_val);
      sender_calm = (ph == 2);
      random_images(PHASE_WORDS);
    end

    push <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
